// ===== src/sha512_pkg.sv =====
`timescale 1ns / 1ps

package sha512_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned Rounds = 80;

  // Request commands carried in tuser.
  localparam logic CmdData   = 1'b0;
  localparam logic CmdFinish = 1'b1;

  typedef logic [WordW-1:0] word_t;

  // Control from the sequencer to the round unit.
  typedef struct packed {
    logic       load;     // copy hash words into the working variables
    logic       round;    // run one round
    logic [6:0] rnd;      // round number
    logic       fold;     // add working variables into the hash words
    logic       restart;  // return hash words to the initial values
  } ctrl_t;

  function automatic word_t round_k(input logic [6:0] idx);
    word_t k;
    unique case (idx)
      7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
      7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
      7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
      7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
      7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic word_t init_hash(input logic [2:0] idx);
    word_t h;
    unique case (idx)
      3'd0: h = 64'h6a09e667f3bcc908;
      3'd1: h = 64'hbb67ae8584caa73b;
      3'd2: h = 64'h3c6ef372fe94f82b;
      3'd3: h = 64'ha54ff53a5f1d36f1;
      3'd4: h = 64'h510e527fade682d1;
      3'd5: h = 64'h9b05688c2b3e6c1f;
      3'd6: h = 64'h1f83d9abfb41bd6b;
      3'd7: h = 64'h5be0cd19137e2179;
      default: h = '0;
    endcase
    return h;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

endpackage

// ===== src/sha512_round.sv =====
`timescale 1ns / 1ps

// One SHA-512 round per cycle: schedule expansion, working variables and
// the hash words. The message window is written by the sequencer.
module sha512_round (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sha512_pkg::ctrl_t   ctrl_i,
  input  logic                win_we_i,
  input  logic [3:0]          win_idx_i,
  input  sha512_pkg::word_t   win_data_i,
  input  logic [2:0]          hash_idx_i,
  output sha512_pkg::word_t   hash_o,
  output sha512_pkg::word_t   win_rd_o
);

  sha512_pkg::word_t win_q [16];
  sha512_pkg::word_t var_q [8];
  sha512_pkg::word_t hash_q [8];

  logic [3:0]        t;
  sha512_pkg::word_t a2, a15, g0, g1, w, s0, s1, ch, mj, t1, t2;

  assign t   = ctrl_i.rnd[3:0];
  assign a2  = win_q[t + 4'd14];
  assign a15 = win_q[t + 4'd1];
  assign g1  = sha512_pkg::rotr(a2, 19) ^ sha512_pkg::rotr(a2, 61) ^ (a2 >> 6);
  assign g0  = sha512_pkg::rotr(a15, 1) ^ sha512_pkg::rotr(a15, 8) ^ (a15 >> 7);
  assign w   = (ctrl_i.rnd >= 7'd16) ? (g1 + win_q[t + 4'd9] + g0 + win_q[t]) : win_q[t];
  assign s1  = sha512_pkg::rotr(var_q[4], 14) ^ sha512_pkg::rotr(var_q[4], 18)
             ^ sha512_pkg::rotr(var_q[4], 41);
  assign ch  = var_q[6] ^ (var_q[4] & (var_q[5] ^ var_q[6]));
  assign t1  = var_q[7] + s1 + ch + sha512_pkg::round_k(ctrl_i.rnd) + w;
  assign s0  = sha512_pkg::rotr(var_q[0], 28) ^ sha512_pkg::rotr(var_q[0], 34)
             ^ sha512_pkg::rotr(var_q[0], 39);
  assign mj  = (var_q[0] & var_q[1]) | (var_q[2] & (var_q[0] | var_q[1]));
  assign t2  = s0 + mj;

  assign hash_o   = hash_q[hash_idx_i];
  assign win_rd_o = win_q[win_idx_i];

  always_ff @(posedge clk_i) begin
    if (win_we_i) begin
      win_q[win_idx_i] <= win_data_i;
    end else if (ctrl_i.round) begin
      win_q[t] <= w;
    end
    if (ctrl_i.load) begin
      for (int i = 0; i < 8; i++) var_q[i] <= hash_q[i];
    end else if (ctrl_i.round) begin
      var_q[7] <= var_q[6];
      var_q[6] <= var_q[5];
      var_q[5] <= var_q[4];
      var_q[4] <= var_q[3] + t1;
      var_q[3] <= var_q[2];
      var_q[2] <= var_q[1];
      var_q[1] <= var_q[0];
      var_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) hash_q[i] <= sha512_pkg::init_hash(3'(i));
    end else if (ctrl_i.restart) begin
      for (int i = 0; i < 8; i++) hash_q[i] <= sha512_pkg::init_hash(3'(i));
    end else if (ctrl_i.fold) begin
      for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + var_q[i];
    end
  end

endmodule

// ===== src/sha512_hash_engine.sv =====
`timescale 1ns / 1ps

// Channel  Dir  tdata                               tuser
// s_axis   in   [7:0] data_byte                     [0] command
// m_axis   out  [63:0] digest_word, [66:64] index   tlast = last_word
//
// A data request only merges its byte into the window, except the 128th byte
// of a block, which starts an 80-round compression (load, 80 rounds, fold) on
// the single shared round unit. A finish request clears the remaining block
// words one per cycle, compresses one or two blocks, then shows eight digest
// words, one per accepted output beat. Reset is asynchronous, active low,
// and returns the engine to the initial hash. Output stalls hold the engine.
module sha512_hash_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // [63:0] digest_word, [66:64] word_index
  output logic        m_axis_tlast_o
);

  typedef enum logic [2:0] {
    StIdle, StPad, StLoad, StRound, StFold, StOut
  } state_e;

  state_e              state_q;
  logic [6:0]          fill_q, rnd_q;
  logic [63:0]         bits_q;
  logic                fin_q;     // a finish is in progress
  logic                lenblk_q;  // the block being compressed is the last one
  logic [3:0]          pad_q;
  logic [2:0]          oidx_q;
  sha512_pkg::ctrl_t   ctrl;
  logic                win_we;
  logic [3:0]          win_idx;
  sha512_pkg::word_t   win_data, win_rd, hash_w;
  logic [2:0]          sh;
  logic                acc;
  logic [7:0]          in_byte;

  assign acc = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == StIdle);
  assign sh = 3'd7 - fill_q[2:0];
  // A finish places the 0x80 pad byte where the next data byte would go.
  assign in_byte = (s_axis_tuser_i == sha512_pkg::CmdFinish) ? 8'h80 : s_axis_tdata_i;

  // Byte merge into the window, or padding writes.
  always_comb begin
    win_we   = 1'b0;
    win_idx  = fill_q[6:3];
    win_data = '0;
    if (acc) begin
      win_we = 1'b1;
      if (fill_q[2:0] == 3'd0) begin
        win_data = {in_byte, 56'd0};
      end else begin
        win_data = win_rd | (64'(in_byte) << {sh, 3'd0});
      end
    end else if (state_q == StPad) begin
      win_we  = 1'b1;
      win_idx = pad_q;
      win_data = (lenblk_q && pad_q == 4'd15) ? bits_q : '0;
    end
  end

  always_comb begin
    ctrl.load    = (state_q == StLoad);
    ctrl.round   = (state_q == StRound);
    ctrl.rnd     = rnd_q;
    ctrl.fold    = (state_q == StFold);
    ctrl.restart = (state_q == StOut) && m_axis_tready_i && (oidx_q == 3'd7);
  end

  sha512_round u_round (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .win_we_i   (win_we),
    .win_idx_i  (win_idx),
    .win_data_i (win_data),
    .hash_idx_i (oidx_q),
    .hash_o     (hash_w),
    .win_rd_o   (win_rd)
  );

  assign m_axis_tvalid_o = (state_q == StOut);
  assign m_axis_tdata_o  = {5'd0, oidx_q, hash_w};
  assign m_axis_tlast_o  = (oidx_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      fill_q   <= '0;
      rnd_q    <= '0;
      bits_q   <= '0;
      fin_q    <= 1'b0;
      lenblk_q <= 1'b0;
      pad_q    <= '0;
      oidx_q   <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (acc) begin
            if (s_axis_tuser_i == sha512_pkg::CmdData) begin
              bits_q <= bits_q + 64'd8;
              fill_q <= fill_q + 7'd1;
              if (fill_q == 7'd127) state_q <= StLoad;
            end else begin
              fin_q    <= 1'b1;
              lenblk_q <= (fill_q < 7'd112);
              pad_q    <= fill_q[6:3] + 4'd1;
              // The 0x80 byte sat in the last word: nothing to clear.
              if (fill_q[6:3] == 4'd15) state_q <= StLoad;
              else state_q <= StPad;
            end
          end
        end
        StPad: begin
          pad_q <= pad_q + 4'd1;
          if (pad_q == 4'd15) state_q <= StLoad;
        end
        StLoad: begin
          rnd_q   <= '0;
          state_q <= StRound;
        end
        StRound: begin
          rnd_q <= rnd_q + 7'd1;
          if (rnd_q == 7'(sha512_pkg::Rounds - 1)) state_q <= StFold;
        end
        StFold: begin
          rnd_q <= '0;
          if (!fin_q) begin
            fill_q  <= '0;
            state_q <= StIdle;
          end else if (lenblk_q) begin
            oidx_q  <= '0;
            state_q <= StOut;
          end else begin
            // Length goes in a fresh all-zero block.
            lenblk_q <= 1'b1;
            pad_q    <= '0;
            state_q  <= StPad;
          end
        end
        StOut: begin
          if (m_axis_tready_i) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == 3'd7) begin
              fin_q   <= 1'b0;
              fill_q  <= '0;
              bits_q  <= '0;
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef SYNTH
  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRound |-> rnd_q < 7'(sha512_pkg::Rounds))
    else $error("round counter out of range");
  a_out_needs_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> fin_q && lenblk_q)
    else $error("digest shown without a finish");
  a_fold_after_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StFold |-> $past(state_q) == StRound)
    else $error("fold without rounds");
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !fin_q)
    else $error("ready during finish");
`endif

endmodule
